// ----- sv/lcdscr_pkg.sv -----
// Shared types and constants for the two-line character LCD scroller.
`default_nettype none
package lcdscr_pkg;

  // Input kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Character and buffer limits.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [5:0] MAX_CHARS    = 6'd39;

  // Controller command codes.
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_SHIFT_LEFT = 8'h18;
  localparam logic [7:0] CMD_ADDR       = 8'h80;
  localparam logic [6:0] LINE2_BASE     = 7'h40;

  // Longest burst that one item can produce.
  localparam int MAX_WRITES = 5;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Character or shift work that follows an optional clear sequence.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DATA1,
    OP_WRAP,
    OP_DATA2,
    OP_SHIFT
  } op_t;

  // One classified item, as the back part needs it to build its writes.
  typedef struct packed {
    logic       clr;
    op_t        op;
    logic [7:0] ch;
    logic [5:0] pos;
    logic       done;
  } desc_t;

endpackage
`default_nettype wire

// ----- sv/lcdscr_front.sv -----
// Front part: accepts items, updates the counters and classifies each item.
`default_nettype none
module lcdscr_front
  import lcdscr_pkg::*;
#(
  parameter int COLUMNS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] char_code,
  output desc_t           desc
);

  localparam logic [7:0] SPAN     = 8'(2 * COLUMNS - 1);
  localparam logic [5:0] COLS     = 6'(COLUMNS);
  localparam logic [5:0] COLS_M1  = 6'(COLUMNS - 1);

  logic [5:0] char_total_r, char_total_nxt;
  logic [5:0] scroll_total_r, scroll_total_nxt;
  logic       nl_pending_r, nl_pending_nxt;

  // Next state and classification of the item on the input ports.
  always_comb begin
    char_total_nxt   = char_total_r;
    scroll_total_nxt = scroll_total_r;
    nl_pending_nxt   = nl_pending_r;
    desc.clr  = 1'b0;
    desc.op   = OP_NONE;
    desc.ch   = char_code;
    desc.pos  = char_total_r;
    case (kind)
      KIND_CHAR: begin
        if (nl_pending_r && (char_code != CHAR_NEWLINE)) begin
          desc.clr         = 1'b1;
          char_total_nxt   = '0;
          scroll_total_nxt = '0;
          nl_pending_nxt   = 1'b0;
        end
        if (char_code == CHAR_NEWLINE) begin
          nl_pending_nxt = 1'b1;
        end else if (char_total_nxt < MAX_CHARS) begin
          desc.pos = char_total_nxt;
          if (char_total_nxt >= COLS) begin
            desc.op = OP_DATA2;
          end else if (char_total_nxt == COLS_M1) begin
            desc.op = OP_WRAP;
          end else begin
            desc.op = OP_DATA1;
          end
          char_total_nxt = char_total_nxt + 6'd1;
        end
      end
      KIND_TICK: begin
        if ({2'b00, char_total_r} > ({2'b00, scroll_total_r} + SPAN)) begin
          if (scroll_total_r != '0) begin
            desc.op = OP_SHIFT;
          end
          scroll_total_nxt = scroll_total_r + 6'd1;
        end
      end
      KIND_CLEAR: begin
        desc.clr         = 1'b1;
        char_total_nxt   = '0;
        scroll_total_nxt = '0;
      end
      default: begin
      end
    endcase
    // Scroll status is judged on the state after this item.
    desc.done = ({2'b00, char_total_nxt} <= ({2'b00, scroll_total_nxt} + SPAN));
  end

  // State registers move only when an item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_total_r   <= '0;
      scroll_total_r <= '0;
      nl_pending_r   <= 1'b0;
    end else if (accept) begin
      char_total_r   <= char_total_nxt;
      scroll_total_r <= scroll_total_nxt;
      nl_pending_r   <= nl_pending_nxt;
    end
  end

  // The character count never passes the buffer limit.
  a_char_limit: assert property (@(posedge clk) disable iff (!rst_n)
    char_total_r <= MAX_CHARS)
    else $error("character count beyond buffer limit");

  // Any character other than a newline always leaves the newline flag clear.
  a_nl_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (kind == KIND_CHAR) && (char_code != CHAR_NEWLINE)) |=> !nl_pending_r)
    else $error("newline flag survived a character");

endmodule
`default_nettype wire

// ----- sv/lcdscr_queue.sv -----
// Short queue of classified items between the front and back parts.
`default_nettype none
module lcdscr_queue
  import lcdscr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_en,
  input  wire desc_t wr_desc,
  output logic       full,
  input  wire logic  rd_en,
  output desc_t      rd_desc,
  output logic       nonempty
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);

  desc_t         slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == DEPTH_C);
  assign nonempty = (count_r != '0);
  assign rd_desc  = slot_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // Callers never overfill or overdrain the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && !nonempty))
    else $error("read from an empty queue");

endmodule
`default_nettype wire

// ----- sv/lcdscr_back.sv -----
// Back part: expands each classified item into controller writes, one per cycle while the output register is not held.
`default_nettype none
module lcdscr_back
  import lcdscr_pkg::*;
#(
  parameter int COLUMNS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire desc_t      head,
  input  wire logic       head_valid,
  output logic            head_pop,
  input  wire logic       out_pop,
  output logic            out_valid,
  output logic            out_write_valid,
  output logic            out_is_data,
  output logic [7:0]      out_byte_value,
  output logic            out_last,
  output logic            out_scroll_done
);

  localparam int SW = $clog2(MAX_WRITES);
  localparam logic [6:0] COLS7 = 7'(COLUMNS);

  logic [SW-1:0] step_r;
  logic [SW-1:0] total;
  logic [SW-1:0] op_len;
  logic [SW-1:0] op_step;
  logic          cur_wv, cur_data;
  logic [7:0]    cur_byte;
  logic          cur_last;
  logic          advance;
  logic [6:0]    line2_addr;

  logic          out_valid_r;
  logic          wv_r, data_r, last_r, done_r;
  logic [7:0]    byte_r;

  assign line2_addr = LINE2_BASE + {1'b0, head.pos} - COLS7;

  // Number of writes that the character or shift work adds.
  always_comb begin
    case (head.op)
      OP_DATA1: op_len = SW'(1);
      OP_WRAP:  op_len = SW'(2);
      OP_DATA2: op_len = SW'(4);
      OP_SHIFT: op_len = SW'(1);
      default:  op_len = '0;
    endcase
    total = (head.clr ? SW'(3) : '0) + op_len;
    if (total == '0) begin
      total = SW'(1);
    end
  end

  // Select the write for the current step of the burst.
  always_comb begin
    cur_wv   = 1'b1;
    cur_data = 1'b0;
    cur_byte = '0;
    op_step  = head.clr ? (step_r - SW'(3)) : step_r;
    if (head.clr && (step_r < SW'(3))) begin
      case (step_r)
        SW'(0):  cur_byte = CMD_CLEAR;
        SW'(1):  cur_byte = CMD_HOME;
        default: cur_byte = CMD_ADDR;
      endcase
    end else begin
      case (head.op)
        OP_DATA1: begin
          cur_data = 1'b1;
          cur_byte = head.ch;
        end
        OP_WRAP: begin
          if (op_step == '0) begin
            cur_data = 1'b1;
            cur_byte = head.ch;
          end else begin
            cur_byte = CMD_ADDR | {1'b0, LINE2_BASE};
          end
        end
        OP_DATA2: begin
          case (op_step)
            SW'(0):  cur_byte = CMD_ADDR | {2'b00, head.pos};
            SW'(2):  cur_byte = CMD_ADDR | {1'b0, line2_addr};
            default: begin
              cur_data = 1'b1;
              cur_byte = head.ch;
            end
          endcase
        end
        OP_SHIFT: cur_byte = CMD_SHIFT_LEFT;
        default:  cur_wv = 1'b0;
      endcase
    end
    cur_last = (step_r == (total - SW'(1)));
  end

  // A write moves into the output register whenever that register frees up.
  assign advance  = head_valid && (!out_valid_r || out_pop);
  assign head_pop = advance && cur_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        step_r <= cur_last ? '0 : step_r + SW'(1);
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      wv_r   <= cur_wv;
      data_r <= cur_data;
      byte_r <= cur_byte;
      last_r <= cur_last;
      done_r <= head.done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_valid = wv_r;
  assign out_is_data     = data_r;
  assign out_byte_value  = byte_r;
  assign out_last        = last_r;
  assign out_scroll_done = done_r;

  // The burst step stays inside the longest burst.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < SW'(MAX_WRITES))
    else $error("burst step out of range");

  // A status-only result always closes its item.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !wv_r) |-> last_r)
    else $error("status-only result without last");

endmodule
`default_nettype wire

// ----- sv/char_lcd_split_line_scroller.sv -----
// Top level of the two-line character LCD scroller command sequencer.
// On an idle block an item's first write reaches the result ports through the queue, then the output register.
// Throughput: one result per cycle while results are popped; an item has 1 to 5 results,
// set by the back part, which sends the writes of a burst one per cycle unless the output register is held.
// The front accepts new items while a burst is under way, until the two-entry queue fills.
// Reset clears both counts, the newline flag, the queue and the output register.
`default_nettype none
module char_lcd_split_line_scroller
  import lcdscr_pkg::*;
#(
  parameter int COLUMNS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_char_code,
  output logic            empty,
  input  wire logic       pop,
  output logic            out_write_valid,
  output logic            out_is_data,
  output logic [7:0]      out_byte_value,
  output logic            out_last,
  output logic            out_scroll_done
);

  desc_t front_desc;
  desc_t head_desc;
  logic  accept;
  logic  head_valid;
  logic  head_pop;
  logic  out_valid;
  logic  out_take;

  assign accept   = push && !full;
  assign out_take = pop && out_valid;
  assign empty    = !out_valid;

  // Classification and state update.
  lcdscr_front #(
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .kind     (in_kind),
    .char_code(in_char_code),
    .desc     (front_desc)
  );

  // Decoupling queue.
  lcdscr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_desc (front_desc),
    .full    (full),
    .rd_en   (head_pop),
    .rd_desc (head_desc),
    .nonempty(head_valid)
  );

  // Write expansion and output register.
  lcdscr_back #(
    .COLUMNS(COLUMNS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head_desc),
    .head_valid     (head_valid),
    .head_pop       (head_pop),
    .out_pop        (out_take),
    .out_valid      (out_valid),
    .out_write_valid(out_write_valid),
    .out_is_data    (out_is_data),
    .out_byte_value (out_byte_value),
    .out_last       (out_last),
    .out_scroll_done(out_scroll_done)
  );

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the two-line character LCD scroller command sequencer.
`timescale 1ns / 1ps
module testbench;
  import lcdscr_pkg::*;

  localparam int COLS = 8;
  localparam int TOTAL_ITEMS = 480;
  localparam int CALM_TAIL = 60;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One controller write as it leaves the block.
  typedef struct packed {
    logic       write_valid;
    logic       is_data;
    logic [7:0] byte_value;
    logic       last;
    logic       scroll_done;
  } lcd_write_t;

  // Tracks the display state and holds the writes still owed by the block.
  class lcd_write_scoreboard;
    int unsigned char_total;
    int unsigned scroll_total;
    bit          nl_armed;
    lcd_write_t  owed_writes[$];
    lcd_write_t  burst[$];
    int          errors;

    function void add_write(bit is_data, logic [7:0] value);
      lcd_write_t w;
      w.write_valid = 1'b1;
      w.is_data     = is_data;
      w.byte_value  = value;
      w.last        = 1'b0;
      w.scroll_done = 1'b0;
      burst.push_back(w);
    endfunction

    function void add_address(int unsigned addr);
      add_write(1'b0, CMD_ADDR | {1'b0, addr[6:0]});
    endfunction

    function void clear_sequence();
      char_total   = 0;
      scroll_total = 0;
      add_write(1'b0, CMD_CLEAR);
      add_write(1'b0, CMD_HOME);
      add_address(0);
    endfunction

    function bit all_scrolled();
      return char_total <= scroll_total + 2 * COLS - 1;
    endfunction

    // Predicts the burst of writes that one accepted item causes.
    function void note_item(logic [1:0] kind, logic [7:0] ch);
      lcd_write_t w;
      bit done;
      burst.delete();
      if (kind == KIND_CHAR) begin
        // A pending clear runs before any character other than a newline.
        if (nl_armed && ch != CHAR_NEWLINE) begin
          clear_sequence();
          nl_armed = 1'b0;
        end
        if (ch == CHAR_NEWLINE) begin
          nl_armed = 1'b1;
        end else if (char_total < MAX_CHARS) begin
          if (char_total >= COLS) begin
            add_address(char_total);
            add_write(1'b1, ch);
            add_address(LINE2_BASE + char_total - COLS);
            add_write(1'b1, ch);
          end else begin
            add_write(1'b1, ch);
            if (char_total == COLS - 1) add_address(LINE2_BASE);
          end
          char_total = (char_total + 1) & 6'h3f;
        end
      end else if (kind == KIND_TICK) begin
        // The first step only advances the count; later ones shift the display.
        if (!all_scrolled()) begin
          if (scroll_total != 0) add_write(1'b0, CMD_SHIFT_LEFT);
          scroll_total = (scroll_total + 1) & 6'h3f;
        end
      end else if (kind == KIND_CLEAR) begin
        clear_sequence();
      end
      // An item with no write still answers with one status result.
      if (burst.size() == 0) begin
        w = '0;
        burst.push_back(w);
      end
      done = all_scrolled();
      foreach (burst[i]) begin
        burst[i].scroll_done = done;
        burst[i].last = (i == burst.size() - 1);
        owed_writes.push_back(burst[i]);
      end
    endfunction

    function void report(string field, int exp_val, int act_val);
      if (errors < 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
      errors++;
    endfunction

    // Compares one accepted result with the oldest owed write.
    function void check_result(lcd_write_t got);
      lcd_write_t want;
      if (owed_writes.size() == 0) begin
        if (errors < 100)
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = owed_writes.pop_front();
      if (got.write_valid !== want.write_valid)
        report("write_valid", want.write_valid, got.write_valid);
      if (got.is_data !== want.is_data) report("is_data", want.is_data, got.is_data);
      if (got.byte_value !== want.byte_value)
        report("byte_value", want.byte_value, got.byte_value);
      if (got.last !== want.last) report("last", want.last, got.last);
      if (got.scroll_done !== want.scroll_done)
        report("scroll_done", want.scroll_done, got.scroll_done);
    endfunction
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] in_kind = KIND_CHAR;
  logic [7:0] in_char_code = 8'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_write_valid;
  logic       out_is_data;
  logic [7:0] out_byte_value;
  logic       out_last;
  logic       out_scroll_done;

  lcd_write_scoreboard write_board = new();
  int items_sent = 0;
  bit idle_on = 1'b1;

  char_lcd_split_line_scroller #(.COLUMNS(COLS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_kind         (in_kind),
    .in_char_code    (in_char_code),
    .empty           (empty),
    .pop             (pop),
    .out_write_valid (out_write_valid),
    .out_is_data     (out_is_data),
    .out_byte_value  (out_byte_value),
    .out_last        (out_last),
    .out_scroll_done (out_scroll_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watch both handshakes at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) write_board.note_item(in_kind, in_char_code);
      if (pop && !empty)
        write_board.check_result({out_write_valid, out_is_data, out_byte_value,
                                  out_last, out_scroll_done});
    end
  end

  // Result side: pop in random runs, with stall bursts until the calm tail.
  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        n = $urandom_range(1, 17);
      end else begin
        pop <= 1'b1;
        n = $urandom_range(1, 24);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Offers one item and holds it until the block takes it.
  task automatic feed_item(logic [1:0] kind, logic [7:0] ch);
    push         <= 1'b1;
    in_kind      <= kind;
    in_char_code <= ch;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    idle_on = items_sent < TOTAL_ITEMS - CALM_TAIL;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Any character other than a newline.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CHAR_NEWLINE) c = 8'hff;
    return c;
  endfunction

  // A message: an optional clear, a run of characters, then scroll ticks,
  // with the odd stray item mixed in.
  task automatic feed_message();
    int n_chars;
    int n_ticks;
    int start;
    start = $urandom_range(0, 2);
    if (start == 0) feed_item(KIND_CLEAR, 8'($urandom_range(0, 255)));
    else if (start == 1) feed_item(KIND_CHAR, CHAR_NEWLINE);
    n_chars = ($urandom_range(0, 2) == 0) ? $urandom_range(34, 46) : $urandom_range(1, 24);
    for (int i = 0; i < n_chars && items_sent < TOTAL_ITEMS; i++) begin
      if ($urandom_range(0, 40) == 0) feed_item(KIND_CHAR, CHAR_NEWLINE);
      else feed_item(KIND_CHAR, text_char());
    end
    n_ticks = $urandom_range(0, 30);
    for (int i = 0; i < n_ticks && items_sent < TOTAL_ITEMS; i++) begin
      if ($urandom_range(0, 9) == 0)
        feed_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      else feed_item(KIND_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: status-only items, unused kind, field extremes.
    feed_item(KIND_TICK, 8'h00);
    feed_item(KIND_UNUSED, 8'hff);
    feed_item(KIND_UNUSED, 8'h00);
    feed_item(KIND_CHAR, 8'h00);
    feed_item(KIND_CHAR, 8'hff);
    // Fill the first screen, wrapping to the second line, then two later characters.
    for (int i = 0; i < 8; i++) feed_item(KIND_CHAR, 8'(8'h63 + i));
    feed_item(KIND_TICK, 8'hff);
    // Repeated newline only arms the clear; the next character runs it.
    feed_item(KIND_CHAR, CHAR_NEWLINE);
    feed_item(KIND_CHAR, CHAR_NEWLINE);
    feed_item(KIND_CHAR, 8'h6b);
    feed_item(KIND_CLEAR, 8'haa);
    feed_item(KIND_TICK, 8'h55);
    // An explicit clear leaves an armed newline in place.
    feed_item(KIND_CHAR, CHAR_NEWLINE);
    feed_item(KIND_CLEAR, 8'h0a);
    feed_item(KIND_CHAR, 8'h7a);

    // Random: mostly whole messages, some loose noise.
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 4) != 0) feed_message();
      else feed_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
    push <= 1'b0;

    // Drain, then give stray results time to show up.
    while (write_board.owed_writes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (write_board.errors == 0) begin
      $display("[char_lcd_split_line_scroller] OK");
    end else begin
      $display("[char_lcd_split_line_scroller] ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("[char_lcd_split_line_scroller] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
sv/lcdscr_pkg.sv
sv/lcdscr_front.sv
sv/lcdscr_queue.sv
sv/lcdscr_back.sv
sv/char_lcd_split_line_scroller.sv
bench/testbench.sv
